### design/strn_pkg.sv
package strn_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_DST,
    ST_DOT0,
    ST_DOT1,
    ST_DOT2,
    ST_BSQ,
    ST_RSQ,
    ST_DX2,
    ST_DY2,
    ST_DZ2,
    ST_CCHK,
    ST_SQRT,
    ST_ROOT,
    ST_NEXT,
    ST_FIN,
    ST_PNT,
    ST_NDIV,
    ST_NSTORE,
    ST_OUT
  } strn_state_t;

  localparam int unsigned NormLim = 131072;

endpackage

### design/sphere_tree_ray_nearest_hit_core.sv
// Ray against a flattened sphere tree, nearest hit. A load transfer writes one node on the
// accepting edge and passes through ST_OUT before its all-zero result is offered. A trace
// transfer walks nodes 0 to min(node_count, MAX_NODES)-1 with one shared multiply-accumulate
// unit and a square root that settles one root bit per cycle. A bounding sphere is rejected
// either on its discriminant or on its root; for a node whose bounding sphere is met, the
// object sphere is then tested on its discriminant and its root. When a hit was found the
// normal is formed at the end by restoring division, one per axis (skipped for a zero
// radius). The node store is a single-port memory with a registered read. The input stalls
// while an item is in progress and while a result waits.
module sphere_tree_ray_nearest_hit_core #(
  parameter int MAX_NODES = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [10:0]          cfg_node_count,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [9:0]           in_node_index,
  input  logic signed [31:0]   in_node_center_x_in,
  input  logic signed [31:0]   in_node_center_y_in,
  input  logic signed [31:0]   in_node_center_z_in,
  input  logic [30:0]          in_node_radius_in,
  input  logic [10:0]          in_node_skip_in,
  input  logic signed [31:0]   in_ray_origin_x,
  input  logic signed [31:0]   in_ray_origin_y,
  input  logic signed [31:0]   in_ray_origin_z,
  input  logic signed [18:0]   in_ray_dir_x,
  input  logic signed [33:0]   in_ray_dir_yz,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit_found,
  output logic [30:0]          out_hit_distance,
  output logic signed [31:0]   out_hit_point_x,
  output logic signed [31:0]   out_hit_point_y,
  output logic signed [31:0]   out_hit_point_z,
  output logic signed [18:0]   out_normal_x,
  output logic signed [18:0]   out_normal_y,
  output logic signed [18:0]   out_normal_z
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SQB = 64;
  localparam int SRW = 68;
  localparam int DVW = 50 + FRAC_BITS;
  // Operand width of the shared multiplier: b and the hit distance grow as FRAC_BITS shrinks.
  localparam int MW = (FRAC_BITS < 16) ? 54 - FRAC_BITS : 38;
  localparam logic signed [63:0] PLim = 64'sd1 <<< (49 - FRAC_BITS);
  localparam logic signed [63:0] NLim = 64'(strn_pkg::NormLim);

  // Node store.
  logic signed [31:0] mem_cx [MAX_NODES];
  logic signed [31:0] mem_cy [MAX_NODES];
  logic signed [31:0] mem_cz [MAX_NODES];
  logic [30:0]        mem_r  [MAX_NODES];
  logic [10:0]        mem_sk [MAX_NODES];

  strn_pkg::strn_state_t state_r, state_nxt;

  logic [10:0] ncount_r;
  logic [11:0] idx_r;
  logic [11:0] limit;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0] rad_r;
  logic [10:0] skip_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic signed [18:0] dx_r, dy_r, dz_r;
  logic pass_r;             // 0 bounding sphere, 1 object sphere
  logic signed [33:0] ex_r, ey_r, ez_r;
  logic signed [127:0] acc_r;  // shared accumulator
  logic signed [63:0]  b_r;
  logic [127:0] crem_r;
  logic [SRW-1:0] srem_r;
  logic [63:0]  sq_r;
  logic [6:0]   cnt_r;
  logic found_r;
  logic signed [63:0] best_t_r;
  logic [AW-1:0] best_i_r;
  logic [1:0] ax_r;
  logic signed [63:0] pt_r [3];
  logic signed [63:0] nrm_r [3];
  logic [DVW-1:0] dq_r;
  logic [DVW-1:0] drem_r;
  logic dneg_r;
  logic [30:0] brad_r;
  logic in_action_r;

  // Shared multiplier operands.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;

  assign limit = ({1'b0, ncount_r} < 12'(MAX_NODES)) ? {1'b0, ncount_r} : 12'(MAX_NODES);
  assign in_stall = (state_r != strn_pkg::ST_IDLE) || out_valid;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      strn_pkg::ST_DOT0: begin mul_a = MW'(ex_r); mul_b = MW'(dx_r); end
      strn_pkg::ST_DOT1: begin mul_a = MW'(ey_r); mul_b = MW'(dy_r); end
      strn_pkg::ST_DOT2: begin mul_a = MW'(ez_r); mul_b = MW'(dz_r); end
      strn_pkg::ST_BSQ:  begin mul_a = MW'(b_r);  mul_b = MW'(b_r);  end
      strn_pkg::ST_RSQ: begin
        mul_a = pass_r ? MW'({1'b0, rad_r}) : MW'({rad_r, 1'b0});
        mul_b = mul_a;
      end
      strn_pkg::ST_DX2: begin mul_a = MW'(ex_r); mul_b = MW'(ex_r); end
      strn_pkg::ST_DY2: begin mul_a = MW'(ey_r); mul_b = MW'(ey_r); end
      strn_pkg::ST_DZ2: begin mul_a = MW'(ez_r); mul_b = MW'(ez_r); end
      strn_pkg::ST_PNT: begin
        mul_a = MW'(best_t_r);
        unique case (ax_r)
          2'd0:    mul_b = MW'(dx_r);
          2'd1:    mul_b = MW'(dy_r);
          default: mul_b = MW'(dz_r);
        endcase
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Square root step (two radicand bits per cycle, one root bit) and divider step.
  logic [SRW-1:0] sq_sh, sq_trial;
  logic [SRW:0]   sq_diff;
  logic [DVW-1:0] dv_sh;
  logic [DVW:0]   dv_sub;
  assign sq_sh = {srem_r[SRW-3:0], crem_r[127:126]};
  assign sq_trial = {{(SRW-66){1'b0}}, sq_r, 2'b01};
  assign sq_diff = {1'b0, sq_sh} - {1'b0, sq_trial};
  assign dv_sh = {drem_r[DVW-2:0], dq_r[DVW-1]};
  assign dv_sub = {1'b0, dv_sh} - {{(DVW-30){1'b0}}, brad_r};

  logic signed [63:0] rootd, e_v, f_v, t_v;
  assign rootd = $signed(sq_r);
  assign e_v = b_r + rootd;
  assign f_v = b_r - rootd;
  assign t_v = (f_v > 0) ? f_v : e_v;

  logic signed [63:0] diff_c, pt_sel, ctr_sel;
  always_comb begin
    unique case (ax_r)
      2'd0:    begin pt_sel = pt_r[0]; ctr_sel = 64'(cx_r); end
      2'd1:    begin pt_sel = pt_r[1]; ctr_sel = 64'(cy_r); end
      default: begin pt_sel = pt_r[2]; ctr_sel = 64'(cz_r); end
    endcase
    diff_c = pt_sel - ctr_sel;
    if (diff_c < -PLim) diff_c = -PLim;
    else if (diff_c > PLim) diff_c = PLim;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    rd_en = 1'b0;
    rd_addr = idx_r[AW-1:0];
    unique case (state_r)
      strn_pkg::ST_IDLE:
        if (in_valid && !in_stall && in_action) begin
          state_nxt = strn_pkg::ST_NEXT;
        end else if (in_valid && !in_stall) begin
          state_nxt = strn_pkg::ST_OUT;
        end
      strn_pkg::ST_NEXT:
        if (idx_r < limit) begin
          rd_en = 1'b1;
          state_nxt = strn_pkg::ST_RD;
        end else if (found_r) begin
          rd_en = 1'b1;
          rd_addr = best_i_r;
          state_nxt = strn_pkg::ST_RD;
        end else begin
          state_nxt = strn_pkg::ST_OUT;
        end
      strn_pkg::ST_RD:   state_nxt = found_r && idx_r >= limit ? strn_pkg::ST_PNT
                                                               : strn_pkg::ST_DST;
      strn_pkg::ST_DST:  state_nxt = strn_pkg::ST_DOT0;
      strn_pkg::ST_DOT0: state_nxt = strn_pkg::ST_DOT1;
      strn_pkg::ST_DOT1: state_nxt = strn_pkg::ST_DOT2;
      strn_pkg::ST_DOT2: state_nxt = strn_pkg::ST_BSQ;
      strn_pkg::ST_BSQ:  state_nxt = strn_pkg::ST_RSQ;
      strn_pkg::ST_RSQ:  state_nxt = strn_pkg::ST_DX2;
      strn_pkg::ST_DX2:  state_nxt = strn_pkg::ST_DY2;
      strn_pkg::ST_DY2:  state_nxt = strn_pkg::ST_DZ2;
      strn_pkg::ST_DZ2:  state_nxt = strn_pkg::ST_CCHK;
      strn_pkg::ST_CCHK: state_nxt = acc_r[127] ? strn_pkg::ST_NEXT : strn_pkg::ST_SQRT;
      strn_pkg::ST_SQRT: if (cnt_r == 7'd0) state_nxt = strn_pkg::ST_ROOT;
      strn_pkg::ST_ROOT: state_nxt = (!pass_r && e_v >= 0) ? strn_pkg::ST_BSQ
                                                            : strn_pkg::ST_NEXT;
      strn_pkg::ST_PNT:  state_nxt = strn_pkg::ST_FIN;
      strn_pkg::ST_FIN:  state_nxt = (rad_r == '0) ? strn_pkg::ST_NSTORE
                                                    : strn_pkg::ST_NDIV;
      strn_pkg::ST_NDIV: if (cnt_r == 7'd0) state_nxt = strn_pkg::ST_NSTORE;
      strn_pkg::ST_NSTORE: state_nxt = (ax_r == 2'd2) ? strn_pkg::ST_OUT
                                                        : strn_pkg::ST_PNT;
      strn_pkg::ST_OUT:  state_nxt = strn_pkg::ST_IDLE;
      default:           state_nxt = strn_pkg::ST_IDLE;
    endcase
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (state_r == strn_pkg::ST_IDLE && in_valid && !in_stall && !in_action &&
        {22'd0, in_node_index} < 32'(MAX_NODES)) begin
      mem_cx[AW'(in_node_index)] <= in_node_center_x_in;
      mem_cy[AW'(in_node_index)] <= in_node_center_y_in;
      mem_cz[AW'(in_node_index)] <= in_node_center_z_in;
      mem_r[AW'(in_node_index)]  <= in_node_radius_in;
      mem_sk[AW'(in_node_index)] <= in_node_skip_in;
    end
    if (rd_en) begin
      cx_r   <= mem_cx[rd_addr];
      cy_r   <= mem_cy[rd_addr];
      cz_r   <= mem_cz[rd_addr];
      rad_r  <= mem_r[rd_addr];
      skip_r <= mem_sk[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= strn_pkg::ST_IDLE;
      ncount_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) ncount_r <= cfg_node_count;
      if (state_r == strn_pkg::ST_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      strn_pkg::ST_IDLE: begin
        ox_r <= in_ray_origin_x;
        oy_r <= in_ray_origin_y;
        oz_r <= in_ray_origin_z;
        dx_r <= in_ray_dir_x;
        dy_r <= 19'(signed'(in_ray_dir_yz[33:17]));
        dz_r <= 19'(signed'(in_ray_dir_yz[16:0]));
        idx_r <= '0;
        found_r <= 1'b0;
        best_t_r <= '0;
        ax_r <= '0;
      end
      strn_pkg::ST_DST: begin
        ex_r <= 34'(cx_r) - 34'(ox_r);
        ey_r <= 34'(cy_r) - 34'(oy_r);
        ez_r <= 34'(cz_r) - 34'(oz_r);
        pass_r <= 1'b0;
        acc_r <= '0;
      end
      strn_pkg::ST_DOT0, strn_pkg::ST_DOT1:
        acc_r <= acc_r + 128'(mul_p);
      strn_pkg::ST_DOT2:
        b_r <= 64'((acc_r + 128'(mul_p)) >>> FRAC_BITS);
      strn_pkg::ST_BSQ:  acc_r <= 128'(mul_p);
      strn_pkg::ST_RSQ:  acc_r <= acc_r + 128'(mul_p);
      strn_pkg::ST_DX2, strn_pkg::ST_DY2, strn_pkg::ST_DZ2:
        acc_r <= acc_r - 128'(mul_p);
      strn_pkg::ST_CCHK: begin
        crem_r <= acc_r;
        srem_r <= '0;
        sq_r <= '0;
        cnt_r <= 7'(SQB - 1);
        if (acc_r[127]) begin
          if (!pass_r) idx_r <= idx_r + ((skip_r == '0) ? 12'd1 : 12'(skip_r));
          else idx_r <= idx_r + 12'd1;
        end
      end
      strn_pkg::ST_SQRT: begin
        crem_r <= crem_r << 2;
        if (!sq_diff[SRW]) begin
          srem_r <= sq_diff[SRW-1:0];
          sq_r <= {sq_r[62:0], 1'b1};
        end else begin
          srem_r <= sq_sh;
          sq_r <= {sq_r[62:0], 1'b0};
        end
        if (cnt_r != 7'd0) cnt_r <= cnt_r - 7'd1;
      end
      strn_pkg::ST_ROOT: begin
        if (!pass_r) begin
          if (e_v < 0) idx_r <= idx_r + ((skip_r == '0) ? 12'd1 : 12'(skip_r));
          pass_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 12'd1;
          if (e_v >= 0 && (!found_r || t_v < best_t_r)) begin
            found_r <= 1'b1;
            best_t_r <= t_v;
            best_i_r <= idx_r[AW-1:0];
          end
        end
      end
      strn_pkg::ST_PNT: begin
        unique case (ax_r)
          2'd0:    pt_r[0] <= 64'(mul_p >>> FRAC_BITS) + 64'(ox_r);
          2'd1:    pt_r[1] <= 64'(mul_p >>> FRAC_BITS) + 64'(oy_r);
          default: pt_r[2] <= 64'(mul_p >>> FRAC_BITS) + 64'(oz_r);
        endcase
      end
      strn_pkg::ST_FIN: begin
        dneg_r <= diff_c[63];
        dq_r <= DVW'(diff_c[63] ? -diff_c : diff_c) << FRAC_BITS;
        drem_r <= '0;
        brad_r <= rad_r;
        cnt_r <= 7'(DVW - 1);
      end
      strn_pkg::ST_NDIV: begin
        dq_r <= {dq_r[DVW-2:0], ~dv_sub[DVW]};
        drem_r <= dv_sub[DVW] ? dv_sh : dv_sub[DVW-1:0];
        if (cnt_r != 7'd0) cnt_r <= cnt_r - 7'd1;
      end
      strn_pkg::ST_NSTORE: begin
        nrm_r[ax_r] <= (rad_r == '0) ? 64'sd0
                     : (dneg_r ? -$signed(64'(dq_r)) : $signed(64'(dq_r)));
        ax_r <= ax_r + 2'd1;
      end
      default: ;
    endcase
  end

  // Result formation.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
  function automatic logic signed [18:0] satn(input logic signed [63:0] v);
    if (v > NLim) return 19'(NLim);
    if (v < -NLim) return 19'(-NLim);
    return v[18:0];
  endfunction

  always_ff @(posedge clk) begin
    if (state_r == strn_pkg::ST_OUT) begin
      out_hit_found <= found_r && in_action_r;
      out_hit_distance <= (found_r && in_action_r)
                        ? ((best_t_r > 64'sd2147483647) ? 31'h7FFFFFFF
                           : (best_t_r < 0 ? 31'd0 : best_t_r[30:0])) : '0;
      out_hit_point_x <= (found_r && in_action_r) ? sat32(pt_r[0]) : '0;
      out_hit_point_y <= (found_r && in_action_r) ? sat32(pt_r[1]) : '0;
      out_hit_point_z <= (found_r && in_action_r) ? sat32(pt_r[2]) : '0;
      out_normal_x <= (found_r && in_action_r) ? satn(nrm_r[0]) : '0;
      out_normal_y <= (found_r && in_action_r) ? satn(nrm_r[1]) : '0;
      out_normal_z <= (found_r && in_action_r) ? satn(nrm_r[2]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == strn_pkg::ST_IDLE && in_valid && !in_stall) in_action_r <= in_action;
  end

  // Checks.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != strn_pkg::ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == strn_pkg::ST_OUT)) else $error("stray result");
  a_sqrt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == strn_pkg::ST_SQRT) |-> (cnt_r < 7'(SQB))) else $error("sqrt count");

endmodule
